[src/pcd_pkg.sv]
// pcd_pkg.sv: types, constants and the edge check shared by the port change detector.
// Has no dependencies of its own.
package pcd_pkg;

    // Fixed geometry of the scan item and the register map.
    localparam int PINS        = 8;
    localparam int MAX_PORTS   = 5;
    localparam int PORT_W      = 3;
    localparam int SAMPLE_W    = 8;
    localparam int MASK_W      = 40;
    localparam int MODE_W      = 64;
    localparam int MODE4_W     = 16;
    localparam int INCR_W      = 64;
    localparam int APB_DATA_W  = 64;
    localparam int APB_ADDR_W  = 6;

    typedef logic [PORT_W-1:0]   t_port;
    typedef logic [PINS-1:0]     t_pins;
    typedef logic [SAMPLE_W-1:0] t_sample;

    // Register indexes; each register sits at byte address 8 * index.
    typedef enum logic [2:0] {
        CFG_OUTPUT_MASKS  = 3'd0,
        CFG_DIGITAL_MASKS = 3'd1,
        CFG_EDGE_MODES    = 3'd2,
        CFG_EDGE_MODES_P4 = 3'd3,
        CFG_INCREMENTS    = 3'd4
    } t_cfg_reg;

    typedef enum logic [1:0] {
        EDGE_NONE    = 2'd0,
        EDGE_FALLING = 2'd1,
        EDGE_RISING  = 2'd2,
        EDGE_BOTH    = 2'd3
    } t_edge_mode;

    // Edge check of one digital pin against its previous level.
    function automatic logic edge_hit(t_edge_mode mode, logic prev_lvl, logic cur_lvl);
        logic hit;
        unique case (mode)
            EDGE_FALLING: hit = prev_lvl & ~cur_lvl;
            EDGE_RISING:  hit = ~prev_lvl & cur_lvl;
            EDGE_BOTH:    hit = prev_lvl ^ cur_lvl;
            default:      hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

[src/port_change_detector.sv]
// port_change_detector.sv: top level of the port change detector.
// Depends on pcd_pkg for its types, register indexes and the edge check.
//
// The block takes one port scan per transfer (port index, eight digital pin levels and
// eight analog samples) and returns one transfer per scan with the port index and an
// 8-bit change mask. Input pins flagged digital report a falling, rising or either edge
// against the levels stored from the previous scan of the same port; pins flagged analog
// report when the sample differs from the channel's tracked level by at least the
// channel's increment, and only then does the tracked level follow the sample. Output
// pins never report. A scan of a port at or above PORT_COUNT changes nothing and returns
// an all-zero mask. Each scan passes through the input register and then the result
// register, with the pin checks in between. A new scan is accepted every cycle as long
// as results are taken; the result register frees up in the same cycle that its
// transfer completes, so a stalled output holds at most two scans in the block.
// State is updated in scan order as each scan moves into the result register, so
// back-to-back scans of the same port see each other's levels.
// Configuration is through the APB-style port; registers are 64-bit words at byte
// addresses 0, 8, 16, 24 and 32, and should be written only while no scan is in flight.
module port_change_detector #(
    parameter int PORT_COUNT = 5
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    // Scan input channel.
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [pcd_pkg::PORT_W-1:0]          i_port_index,
    input  logic [pcd_pkg::PINS-1:0]            i_digital_value,
    input  logic [pcd_pkg::SAMPLE_W-1:0]        i_analog_sample_0,
    input  logic [pcd_pkg::SAMPLE_W-1:0]        i_analog_sample_1,
    input  logic [pcd_pkg::SAMPLE_W-1:0]        i_analog_sample_2,
    input  logic [pcd_pkg::SAMPLE_W-1:0]        i_analog_sample_3,
    input  logic [pcd_pkg::SAMPLE_W-1:0]        i_analog_sample_4,
    input  logic [pcd_pkg::SAMPLE_W-1:0]        i_analog_sample_5,
    input  logic [pcd_pkg::SAMPLE_W-1:0]        i_analog_sample_6,
    input  logic [pcd_pkg::SAMPLE_W-1:0]        i_analog_sample_7,

    // Result channel.
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [pcd_pkg::PORT_W-1:0]          o_changed_port,
    output logic [pcd_pkg::PINS-1:0]            o_change_mask,

    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pcd_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [pcd_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [pcd_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [pcd_pkg::MASK_W-1:0]  r_output_masks;
    logic [pcd_pkg::MASK_W-1:0]  r_digital_masks;
    logic [pcd_pkg::MODE_W-1:0]  r_edge_modes;
    logic [pcd_pkg::MODE4_W-1:0] r_edge_modes_p4;
    logic [pcd_pkg::INCR_W-1:0]  r_increments;

    pcd_pkg::t_cfg_reg cfg_sel;
    logic              cfg_wr;

    assign pready  = 1'b1;
    assign cfg_sel = pcd_pkg::t_cfg_reg'(paddr[pcd_pkg::APB_ADDR_W-1:3]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_output_masks  <= '1;
            r_digital_masks <= '1;
            r_edge_modes    <= '0;
            r_edge_modes_p4 <= '0;
            r_increments    <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_sel)
                pcd_pkg::CFG_OUTPUT_MASKS:  r_output_masks  <= pwdata[pcd_pkg::MASK_W-1:0];
                pcd_pkg::CFG_DIGITAL_MASKS: r_digital_masks <= pwdata[pcd_pkg::MASK_W-1:0];
                pcd_pkg::CFG_EDGE_MODES:    r_edge_modes    <= pwdata[pcd_pkg::MODE_W-1:0];
                pcd_pkg::CFG_EDGE_MODES_P4: r_edge_modes_p4 <= pwdata[pcd_pkg::MODE4_W-1:0];
                pcd_pkg::CFG_INCREMENTS:    r_increments    <= pwdata[pcd_pkg::INCR_W-1:0];
                default: ;
            endcase
        end
    end

    // Read data, zero-extended to the bus width. Addresses past the map read as zero.
    always_comb begin
        unique case (cfg_sel)
            pcd_pkg::CFG_OUTPUT_MASKS:
                prdata = pcd_pkg::APB_DATA_W'(r_output_masks);
            pcd_pkg::CFG_DIGITAL_MASKS:
                prdata = pcd_pkg::APB_DATA_W'(r_digital_masks);
            pcd_pkg::CFG_EDGE_MODES:
                prdata = pcd_pkg::APB_DATA_W'(r_edge_modes);
            pcd_pkg::CFG_EDGE_MODES_P4:
                prdata = pcd_pkg::APB_DATA_W'(r_edge_modes_p4);
            pcd_pkg::CFG_INCREMENTS:
                prdata = pcd_pkg::APB_DATA_W'(r_increments);
            default:
                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input register and pipeline control
    // ------------------------------------------------------------------
    logic               r_in_valid;
    pcd_pkg::t_port     r_in_port;
    pcd_pkg::t_pins     r_in_digital;
    pcd_pkg::t_sample   r_in_samples [pcd_pkg::PINS];

    logic               r_out_valid;
    pcd_pkg::t_port     r_out_port;
    pcd_pkg::t_pins     r_out_mask;

    logic               advance;
    logic               in_xfer;

    // The scan in the input register moves on whenever the result register is empty
    // or its transfer completes in this cycle.
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;
    assign in_xfer = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_port        <= i_port_index;
            r_in_digital     <= i_digital_value;
            r_in_samples[0]  <= i_analog_sample_0;
            r_in_samples[1]  <= i_analog_sample_1;
            r_in_samples[2]  <= i_analog_sample_2;
            r_in_samples[3]  <= i_analog_sample_3;
            r_in_samples[4]  <= i_analog_sample_4;
            r_in_samples[5]  <= i_analog_sample_5;
            r_in_samples[6]  <= i_analog_sample_6;
            r_in_samples[7]  <= i_analog_sample_7;
        end
    end

    // ------------------------------------------------------------------
    // Stored levels
    // ------------------------------------------------------------------
    pcd_pkg::t_pins   r_prev_levels [PORT_COUNT];
    pcd_pkg::t_sample r_tracked [pcd_pkg::PINS];

    // ------------------------------------------------------------------
    // Per-port selection of configuration and previous levels
    // ------------------------------------------------------------------
    logic                          port_ok;
    pcd_pkg::t_pins                prev_lvls;
    pcd_pkg::t_pins                out_pins;
    pcd_pkg::t_pins                dig_pins;
    logic [pcd_pkg::MODE4_W-1:0]   port_modes;

    always_comb begin
        port_ok    = 1'b0;
        prev_lvls  = '0;
        out_pins   = '1;
        dig_pins   = '0;
        port_modes = '0;
        for (int p = 0; p < PORT_COUNT; p++) begin
            if (r_in_port == pcd_pkg::PORT_W'(p)) begin
                port_ok   = 1'b1;
                prev_lvls = r_prev_levels[p];
            end
        end
        // Pin masks and edge modes come from fixed register slices per port.
        for (int p = 0; p < pcd_pkg::MAX_PORTS; p++) begin
            if (r_in_port == pcd_pkg::PORT_W'(p)) begin
                out_pins = r_output_masks[p*pcd_pkg::PINS +: pcd_pkg::PINS];
                dig_pins = r_digital_masks[p*pcd_pkg::PINS +: pcd_pkg::PINS];
                if (p == pcd_pkg::MAX_PORTS - 1) begin
                    port_modes = r_edge_modes_p4;
                end else begin
                    port_modes = r_edge_modes[p*pcd_pkg::MODE4_W +: pcd_pkg::MODE4_W];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Pin checks, all eight side by side
    // ------------------------------------------------------------------
    pcd_pkg::t_pins    hit;
    pcd_pkg::t_pins    analog_upd;
    pcd_pkg::t_sample  diff [pcd_pkg::PINS];

    always_comb begin
        for (int n = 0; n < pcd_pkg::PINS; n++) begin
            diff[n] = (r_in_samples[n] >= r_tracked[n]) ? (r_in_samples[n] - r_tracked[n])
                                                         : (r_tracked[n] - r_in_samples[n]);
            hit[n]        = 1'b0;
            analog_upd[n] = 1'b0;
            if (port_ok && !out_pins[n]) begin
                if (dig_pins[n]) begin
                    hit[n] = pcd_pkg::edge_hit(pcd_pkg::t_edge_mode'(port_modes[2*n +: 2]),
                                               prev_lvls[n], r_in_digital[n]);
                end else if (diff[n] >= r_increments[n*pcd_pkg::SAMPLE_W +: pcd_pkg::SAMPLE_W]) begin
                    hit[n]        = 1'b1;
                    analog_upd[n] = 1'b1;
                end
            end
        end
    end

    // State moves together with the scan into the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < PORT_COUNT; p++) begin
                r_prev_levels[p] <= '0;
            end
            for (int n = 0; n < pcd_pkg::PINS; n++) begin
                r_tracked[n] <= '0;
            end
        end else if (advance) begin
            for (int p = 0; p < PORT_COUNT; p++) begin
                if (r_in_port == pcd_pkg::PORT_W'(p)) begin
                    r_prev_levels[p] <= r_in_digital;
                end
            end
            for (int n = 0; n < pcd_pkg::PINS; n++) begin
                if (analog_upd[n]) begin
                    r_tracked[n] <= r_in_samples[n];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_port <= r_in_port;
            r_out_mask <= hit;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_changed_port = r_out_port;
    assign o_change_mask  = r_out_mask;

`ifndef ASSERT_OFF
    // The input side only stalls when both registers are full and the output is held.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_in_valid && r_out_valid && !i_ready))
        else $error("input stalled without a full pipeline");

    // A scan that moves on always shows up as a result in the next cycle.
    a_advance_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("advanced scan did not reach the result register");

    // A scan of a port outside the configured range never reports a change.
    a_bad_port_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (int'(r_out_port) >= PORT_COUNT)) |-> (r_out_mask == '0))
        else $error("change reported for an unused port");

    // A blocked scan is kept in the input register.
    a_hold_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_ready) |=> r_in_valid)
        else $error("blocked scan was dropped");
`endif

endmodule
